FILE: hw/rtl/forward_substitution_solver_core_defines.svh
// Assertion macros used by the forward substitution solver checker.
`ifndef FORWARD_SUBSTITUTION_SOLVER_CORE_DEFINES_SVH
`define FORWARD_SUBSTITUTION_SOLVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("forward substitution solver assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("forward substitution solver assertion failed");

`endif

FILE: hw/rtl/fss_pkg.sv
// Package with widths, field positions, microcode types and the microcode table.
package fss_pkg;

    localparam int MAX_ROWS_DEFAULT  = 256;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int IDX_W      = 8;
    localparam int VAL_W      = 32;
    localparam int SIZE_W     = 9;
    localparam int ACC_W      = 64;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = 8;
    localparam int COEF_LSB   = 16;
    localparam int RHS_LSB    = 48;
    localparam int SOL_IDX_LSB = 0;
    localparam int SOL_VAL_LSB = 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam int DIV_STEPS = ACC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_NUM,
        ST_LOAD,
        ST_DIV,
        ST_RESULT,
        ST_SINGULAR
    } step_t;

    typedef enum logic [1:0] {
        SEQ_DISPATCH,
        SEQ_GOTO,
        SEQ_LOOP,
        SEQ_HOLD
    } seq_op_t;

    typedef struct packed {
        logic    take_in;
        logic    do_mul;
        logic    do_acc;
        logic    do_num;
        logic    do_load;
        logic    do_div;
        logic    do_result;
        logic    result_sing;
        seq_op_t seq;
        step_t   target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        w.seq = SEQ_GOTO;
        w.target = ST_IDLE;
        case (step)
            ST_IDLE:
            begin
                w.take_in = 1'b1;
                w.seq = SEQ_DISPATCH;
            end
            ST_MUL:
            begin
                w.do_mul = 1'b1;
                w.target = ST_ACC;
            end
            ST_ACC:
            begin
                w.do_acc = 1'b1;
            end
            ST_NUM:
            begin
                w.do_num = 1'b1;
                w.target = ST_LOAD;
            end
            ST_LOAD:
            begin
                w.do_load = 1'b1;
                w.target = ST_DIV;
            end
            ST_DIV:
            begin
                w.do_div = 1'b1;
                w.seq = SEQ_LOOP;
                w.target = ST_RESULT;
            end
            ST_RESULT:
            begin
                w.do_result = 1'b1;
                w.seq = SEQ_HOLD;
            end
            ST_SINGULAR:
            begin
                w.do_result = 1'b1;
                w.result_sing = 1'b1;
                w.seq = SEQ_HOLD;
            end
            default:
            begin
                w.seq = SEQ_GOTO;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/forward_substitution_solver_core.sv
// Top level of the microcoded forward substitution solver for lower-triangular systems.
//
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   row, col, coefficient, rhs
// m_axis    out        m_axis_tvalid / m_axis_tready   index, value; tuser singular; tlast
// cfg       in         cfg_we                          matrix_size
//
// An off-diagonal entry passes through store read, multiply and accumulate; an upper entry is discarded.
// A diagonal entry runs numerator, load, the 64-step radix-2 divider and result; a zero diagonal is singular.
// Reset idles the sequencer, clears the accumulator and output valid, and loads size 256; no clearing pass.
// One finished result waits in the output register while the next entry is accepted.
// A further result waits in its final step until the output register is free.
module forward_substitution_solver_core #(
    parameter int MAX_ROWS  = fss_pkg::MAX_ROWS_DEFAULT,
    parameter int FRAC_BITS = fss_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: row_index, col_index, coefficient, rhs_value.
    input  logic [fss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: solution_index, solution_value.
    output logic [fss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Fields from bit 0: singular.
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [fss_pkg::SIZE_W-1:0]      cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_ROWS);
    localparam int IDX_W  = fss_pkg::IDX_W;
    localparam int VAL_W  = fss_pkg::VAL_W;
    localparam int ACC_W  = fss_pkg::ACC_W;
    localparam int CNT_W  = fss_pkg::CNT_W;
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] v;
        v = idx;
        for (int k = IDX_W - 1; k >= 0; k--)
        begin
            if (32'(v) >= (MAX_ROWS << k))
            begin
                v = v - IDX_W'(MAX_ROWS << k);
            end
        end
        return ADDR_W'(v);
    endfunction

    fss_pkg::step_t  step_reg, step_next;
    fss_pkg::ucode_t cw;

    logic [IDX_W-1:0]         in_row, in_col;
    logic [VAL_W-1:0]         in_coef, in_rhs;
    logic                     in_accept, out_free, last_iter;

    logic [IDX_W-1:0]         row_reg, row_next;
    logic signed [VAL_W-1:0]  coef_reg, coef_next;
    logic [VAL_W-1:0]         rhs_reg, rhs_next;
    logic signed [ACC_W-1:0]  prod_reg, prod_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [ACC_W-1:0]         num_reg, num_next;
    logic [VAL_W-1:0]         rem_reg, rem_next;
    logic [VAL_W-1:0]         den_reg, den_next;
    logic [ACC_W-1:0]         quo_reg, quo_next;
    logic                     neg_reg, neg_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [fss_pkg::SIZE_W-1:0] size_reg, size_next;
    logic                     m_valid_reg, m_valid_next;
    logic [fss_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                     m_sing_reg, m_sing_next;
    logic                     m_last_reg, m_last_next;

    logic signed [VAL_W-1:0]  x_value;
    logic [ACC_W:0]           acc_sum, num_diff;
    logic [ACC_W-1:0]         rhs_wide, acc_sat, num_sat;
    logic [VAL_W:0]           rem_shift, rem_diff;
    logic                     quo_hi;
    logic [VAL_W-1:0]         quo_value, res_value;
    logic                     store_we;

    fss_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ROWS)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (store_addr(row_reg)),
        .wr_data (res_value),
        .rd_addr (store_addr(in_col)),
        .rd_data (x_value)
    );

    assign in_row  = s_axis_tdata[fss_pkg::ROW_LSB +: IDX_W];
    assign in_col  = s_axis_tdata[fss_pkg::COL_LSB +: IDX_W];
    assign in_coef = s_axis_tdata[fss_pkg::COEF_LSB +: VAL_W];
    assign in_rhs  = s_axis_tdata[fss_pkg::RHS_LSB +: VAL_W];

    assign cw        = fss_pkg::ucode_rom(step_reg);
    assign in_accept = s_axis_tvalid && cw.take_in;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign last_iter = (cnt_reg == CNT_W'(fss_pkg::DIV_STEPS - 1));

    always_comb
    begin
        step_next = step_reg;
        case (cw.seq)
            fss_pkg::SEQ_DISPATCH:
            begin
                if (in_accept && (in_col < in_row))
                begin
                    step_next = fss_pkg::ST_MUL;
                end
                else if (in_accept && (in_col == in_row))
                begin
                    step_next = (in_coef == '0) ? fss_pkg::ST_SINGULAR : fss_pkg::ST_NUM;
                end
                else
                begin
                    step_next = cw.target;
                end
            end
            fss_pkg::SEQ_GOTO:
            begin
                step_next = cw.target;
            end
            fss_pkg::SEQ_LOOP:
            begin
                step_next = last_iter ? cw.target : step_reg;
            end
            fss_pkg::SEQ_HOLD:
            begin
                step_next = out_free ? cw.target : step_reg;
            end
            default:
            begin
                step_next = fss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rhs_wide = {{(ACC_W-VAL_W){rhs_reg[VAL_W-1]}}, rhs_reg} << FRAC_BITS;
        acc_sum  = {acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg};
        num_diff = {rhs_wide[ACC_W-1], rhs_wide} - {acc_reg[ACC_W-1], acc_reg};
        acc_sat  = (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                 ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];
        num_sat  = (num_diff[ACC_W] != num_diff[ACC_W-1])
                 ? (num_diff[ACC_W] ? ACC_MIN : ACC_MAX) : num_diff[ACC_W-1:0];

        rem_shift = {rem_reg, quo_reg[ACC_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};

        quo_hi = |quo_reg[ACC_W-1:VAL_W-1];
        if (neg_reg)
        begin
            quo_value = quo_hi ? VAL_MIN : (VAL_W'(0) - quo_reg[VAL_W-1:0]);
        end
        else
        begin
            quo_value = quo_hi ? VAL_MAX : quo_reg[VAL_W-1:0];
        end
        res_value = cw.result_sing ? '0 : quo_value;
        store_we  = cw.do_result && out_free;
    end

    always_comb
    begin
        row_next  = row_reg;
        coef_next = coef_reg;
        rhs_next  = rhs_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        size_next = cfg_we ? cfg_wdata : size_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_sing_next  = m_sing_reg;
        m_last_next  = m_last_reg;

        if (in_accept)
        begin
            row_next  = in_row;
            coef_next = in_coef;
            rhs_next  = in_rhs;
        end
        if (cw.do_mul)
        begin
            prod_next = coef_reg * x_value;
        end
        if (cw.do_acc)
        begin
            acc_next = acc_sat;
        end
        if (cw.do_num)
        begin
            num_next = num_sat;
        end
        if (cw.do_load)
        begin
            quo_next = num_reg[ACC_W-1] ? (ACC_W'(0) - num_reg) : num_reg;
            den_next = coef_reg[VAL_W-1] ? (VAL_W'(0) - coef_reg) : coef_reg;
            neg_next = num_reg[ACC_W-1] ^ coef_reg[VAL_W-1];
            rem_next = '0;
            cnt_next = '0;
        end
        if (cw.do_div)
        begin
            if (!rem_diff[VAL_W])
            begin
                rem_next = rem_diff[VAL_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[VAL_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (store_we)
        begin
            acc_next     = '0;
            m_valid_next = 1'b1;
            m_data_next  = {res_value, row_reg};
            m_sing_next  = cw.result_sing;
            m_last_next  = (({1'b0, row_reg}) + fss_pkg::SIZE_W'(1)) == size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= fss_pkg::ST_IDLE;
            acc_reg     <= '0;
            size_reg    <= fss_pkg::SIZE_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            acc_reg     <= acc_next;
            size_reg    <= size_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        coef_reg   <= coef_next;
        rhs_reg    <= rhs_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
        m_sing_reg <= m_sing_next;
        m_last_reg <= m_last_next;
    end

    assign s_axis_tready = cw.take_in;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_sing_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

FILE: hw/rtl/fss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/fss_checker.sv
// Port-level checker for the forward substitution solver and its bind statement.
`include "forward_substitution_solver_core_defines.svh"

module fss_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [fss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);

    logic in_xact;
    logic in_wait;
    logic out_stall;
    logic sing_out;
    logic [fss_pkg::OUT_DATA_W+1:0] out_word;
    logic [fss_pkg::VAL_W-1:0]      out_value;

    assign in_xact   = s_axis_tvalid && s_axis_tready;
    assign in_wait   = s_axis_tvalid && !s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign sing_out  = m_axis_tvalid && m_axis_tuser;
    assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign out_value = m_axis_tdata[fss_pkg::SOL_VAL_LSB +: fss_pkg::VAL_W];

    // A stalled result keeps all of its fields.
    `FSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))

    // A waiting input transaction keeps its data.
    `FSS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, s_axis_tvalid && $stable(s_axis_tdata))

    // A new result is never produced in the cycle that follows an input transaction.
    `FSS_ASSERT_IMPL(a_no_result_after_input, clk, rst_n, $rose(m_axis_tvalid), !$past(in_xact))

    // A singular result always carries a zero solution value.
    `FSS_ASSERT_IMPL(a_singular_zero, clk, rst_n, sing_out, out_value == '0)

endmodule

bind forward_substitution_solver_core fss_checker u_fss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
